[sv/mpq_pkg.sv]
// shared types and codes for the min priority queue
package mpq_pkg;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // value returned by a remove on an empty queue
   localparam logic signed [31:0] EMPTY_MARK = 32'sh7fff_ffff;

   // request transaction
   typedef struct packed {
      logic              op;
      logic signed [31:0] value;
   } req_type;

   // response transaction
   typedef struct packed {
      logic signed [31:0] min_value;
      logic [1:0]         status;
      logic [6:0]         count;
   } rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic signed [31:0] value;
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic              valid;
      logic              gt;
      logic signed [31:0] value;
   } cell_link_type;

endpackage

[sv/mpq_cell.sv]
// one cell of the sorted shift chain
module mpq_cell
   import mpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  cell_link_type left_link,
   input  cell_link_type right_link,
   output cell_link_type link
);

   logic               valid_ff, valid_in;
   logic signed [31:0] value_ff, value_in;
   logic               gt;

   // new value goes at or before this cell
   assign gt = !valid_ff || (cmd.value < value_ff);

   assign link.valid = valid_ff;
   assign link.gt    = gt;
   assign link.value = value_ff;

   // insert shifts larger entries right, remove shifts everything left
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.ins) begin
         valid_in = valid_ff || left_link.valid;
         if (gt) begin
            value_in = left_link.gt ? left_link.value : cmd.value;
         end
      end else if (cmd.rem) begin
         valid_in = right_link.valid;
         value_in = right_link.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

[sv/min_priority_queue.sv]
// top level of the min priority queue: cell chain, occupancy and response register
//
//   channel   ports                         direction  accepted when
//   request   start, busy, req_payload      in         start && !busy at clock edge
//   response  rsp_valid, rsp_payload        out        every cycle rsp_valid is high
//
// one transaction per clock; busy stays low, the cell chain finishes an insert
// or remove in the cycle it is accepted.
// the response appears in the cycle after acceptance and is held for one cycle only.
// synchronous reset empties the queue by clearing the cell valid bits at once.
// the receiver cannot stall; nothing waits on it.
module min_priority_queue
   import mpq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]   occ_ff, occ_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff, rsp_in;
   logic            accept, full, empty;
   cell_cmd_type    cmd;
   cell_link_type   links [CAPACITY];
   cell_link_type   head_link, tail_link;
   logic [CW+6:0]   occ_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (occ_ff == CW'(CAPACITY));
   assign empty  = (occ_ff == '0);

   // command to the chain, rejected operations do nothing
   assign cmd.ins   = accept && (req_payload.op == OP_INSERT) && !full;
   assign cmd.rem   = accept && (req_payload.op == OP_REMOVE) && !empty;
   assign cmd.value = req_payload.value;

   // chain ends
   assign head_link = '{valid: 1'b1, gt: 1'b0, value: '0};
   assign tail_link = '{valid: 1'b0, gt: 1'b1, value: '0};

   // cell row, cell 0 holds the minimum
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type lft, rgt;
      if (i == 0) begin : g_head
         assign lft = head_link;
      end else begin : g_mid_l
         assign lft = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign rgt = tail_link;
      end else begin : g_mid_r
         assign rgt = links[i+1];
      end
      mpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (lft),
         .right_link (rgt),
         .link       (links[i])
      );
   end

   // occupancy update
   always_comb begin
      occ_in = occ_ff;
      if (cmd.ins) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.rem) begin
         occ_in = occ_ff - CW'(1);
      end
   end

   assign occ_ext = {7'b0, occ_in};

   // response for the accepted transaction
   always_comb begin
      rsp_in.min_value = '0;
      rsp_in.status    = ST_OK;
      rsp_in.count     = occ_ext[6:0];
      if (req_payload.op == OP_REMOVE) begin
         if (empty) begin
            rsp_in.min_value = EMPTY_MARK;
            rsp_in.status    = ST_EMPTY;
         end else begin
            rsp_in.min_value = links[0].value;
         end
      end else if (full) begin
         rsp_in.status = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= accept;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sv/mpq_checker.sv]
// port-level checks for the min priority queue and their bind
module mpq_checker
   import mpq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   localparam logic [6:0] CAP_LOW = 7'(CAPACITY % 128);

   // every accepted transaction gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("missing response");

   // no response without an accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset))
      else $error("response without request");

   // remove on empty returns the mark and a zero count
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_EMPTY) |->
      (rsp_payload.min_value == EMPTY_MARK && rsp_payload.count == 7'd0))
      else $error("bad empty response");

   // rejected insert reports a full queue
   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_FULL) |->
      (rsp_payload.min_value == '0 && rsp_payload.count == CAP_LOW
       && $past(req_payload.op) == OP_INSERT))
      else $error("bad full response");

endmodule

bind min_priority_queue mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

[bench/min_priority_queue_tb.sv]
// self-checking testbench for the min priority queue: directed corners, fill/drain and random traffic
`timescale 1ns / 100ps

module min_priority_queue_tb;
   import mpq_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 95;

   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;

   // mirror of the stored values in insertion order
   logic signed [31:0] stored_values[$];
   // responses predicted for accepted transactions, oldest first
   rsp_type            predicted_rsp[$];

   int error_count;
   int checked_count;
   int insert_count;
   int remove_count;
   int full_count;
   int empty_count;
   int cycle_count;
   bit no_idle;

   min_priority_queue #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // apply one transaction to the mirror and return the response it should give
   function automatic rsp_type queue_step(req_type t);
      rsp_type r;
      int      best;
      int      i;
      r.min_value = '0;
      r.status    = ST_OK;
      if (t.op == OP_REMOVE) begin
         if (stored_values.size() == 0) begin
            r.status    = ST_EMPTY;
            r.min_value = EMPTY_MARK;
         end else begin
            // first copy of the smallest value goes
            best = 0;
            for (i = 1; i < stored_values.size(); i++) begin
               if (stored_values[i] < stored_values[best]) best = i;
            end
            r.min_value = stored_values[best];
            stored_values.delete(best);
         end
      end else begin
         if (stored_values.size() >= CAPACITY) r.status = ST_FULL;
         else stored_values.push_back(t.value);
      end
      r.count = 7'(stored_values.size());
      return r;
   endfunction

   // value mix: wide random, narrow band for duplicates, extremes
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom;
      if (r < 8) return int'($urandom_range(0, 15)) - 8;
      case ($urandom_range(0, 5))
         0: return INT_MIN;
         1: return INT_MAX;
         2: return INT_MIN + 1;
         3: return INT_MAX - 1;
         4: return -1;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string field, logic signed [31:0] want,
                                  logic signed [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endtask

   // response check, one transaction per strobe
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (predicted_rsp.size() == 0) begin
            error_count++;
            $display("%0t: response with no transaction pending, actual %0d/%0d/%0d",
                     $time, rsp_payload.min_value, rsp_payload.status, rsp_payload.count);
         end else begin
            want = predicted_rsp.pop_front();
            checked_count++;
            if (rsp_payload.min_value !== want.min_value)
               report_mismatch("min_value", want.min_value, rsp_payload.min_value);
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_payload.status));
            if (rsp_payload.count !== want.count)
               report_mismatch("count", 32'(want.count), 32'(rsp_payload.count));
         end
      end
   end

   // drive one transaction and wait until it is accepted
   task automatic send_item(logic op, logic signed [31:0] value);
      req_type t;
      rsp_type r;
      t.op    = op;
      t.value = value;
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      r = queue_step(t);
      predicted_rsp.push_back(r);
      if (op == OP_REMOVE) remove_count++;
      else insert_count++;
      if (r.status == ST_FULL) full_count++;
      if (r.status == ST_EMPTY) empty_count++;
   endtask

   // start low for an idle stretch, payload scrambled meanwhile
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start       <= 1'b0;
         req_payload <= {1'($urandom), 32'($urandom)};
      end
   endtask

   task automatic random_gap();
      int r;
      if (no_idle) return;
      r = $urandom_range(0, 99);
      if (r < 55) return;
      if (r < 90) idle_cycles($urandom_range(1, 3));
      else idle_cycles($urandom_range(8, 30));
   endtask

   // hold off until every predicted response has been checked
   task automatic wait_for_responses();
      @(negedge clock);
      start <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
   endtask

   // removes on an empty queue, a single entry round trip, then another remove on empty
   task automatic test_empty_remove();
      send_item(OP_REMOVE, 32'sd0);
      send_item(OP_REMOVE, INT_MIN);
      send_item(OP_INSERT, 32'sd42);
      send_item(OP_REMOVE, -32'sd1);
      send_item(OP_REMOVE, INT_MAX);
      wait_for_responses();
   endtask

   // extremes of the value range come back in ascending order
   task automatic test_extreme_values();
      send_item(OP_INSERT, INT_MAX);
      send_item(OP_INSERT, INT_MIN);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, INT_MAX - 1);
      send_item(OP_INSERT, INT_MIN + 1);
      repeat (6) send_item(OP_REMOVE, 32'sd0);
      wait_for_responses();
   endtask

   // equal minima: one copy leaves per remove
   task automatic test_equal_minima();
      send_item(OP_INSERT, 32'sd7);
      send_item(OP_INSERT, -32'sd3);
      send_item(OP_INSERT, -32'sd3);
      send_item(OP_INSERT, 32'sd7);
      repeat (4) send_item(OP_REMOVE, 32'sd0);
      wait_for_responses();
   endtask

   // empty the queue, fill to capacity, push past it, then drain past empty
   task automatic test_fill_to_full();
      no_idle = 1'b0;
      while (stored_values.size() > 0) send_item(OP_REMOVE, pick_value());
      while (stored_values.size() < CAPACITY) begin
         send_item(OP_INSERT, pick_value());
         random_gap();
      end
      repeat (3) send_item(OP_INSERT, pick_value());
      send_item(OP_REMOVE, pick_value());
      send_item(OP_INSERT, pick_value());
      send_item(OP_INSERT, pick_value());
      while (stored_values.size() > 0) begin
         send_item(OP_REMOVE, pick_value());
         random_gap();
      end
      send_item(OP_REMOVE, pick_value());
      wait_for_responses();
   endtask

   // random phases biased toward filling, draining or neither
   task automatic test_random_traffic();
      int  insert_pct;
      logic op;
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 2))
            0: insert_pct = 75;
            1: insert_pct = 25;
            default: insert_pct = 50;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            send_item(op, pick_value());
            random_gap();
         end
         if ($urandom_range(0, 2) == 0) wait_for_responses();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      error_count = 0;
      checked_count = 0;
      insert_count = 0;
      remove_count = 0;
      full_count  = 0;
      empty_count = 0;
      cycle_count = 0;
      no_idle     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_remove();
      test_extreme_values();
      test_equal_minima();
      test_fill_to_full();
      test_random_traffic();

      wait_for_responses();
      repeat (5) @(posedge clock);
      if (predicted_rsp.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, predicted_rsp.size());
      end

      $display("checked %0d responses: %0d inserts (%0d rejected full), %0d removes (%0d on empty)",
               checked_count, insert_count, full_count, remove_count, empty_count);
      $display("stimulus: value extremes, duplicate minima, full and empty edges, biased phases");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
